FILE: rtl/core/pks_pkg.sv
// Shared field widths and arithmetic constants for the polyline knee splitter.
`default_nettype none

package pks_pkg;

   // Width of the coordinate fields on both channels.
   localparam int COORD_W    = 16;
   // Width of the signed knee threshold register.
   localparam int THR_W      = 16;
   // Width of the threshold magnitude and of its square.
   localparam int TMAG_W     = 16;
   localparam int TSQ_W      = 31;
   // The dot product is scaled by 2**14 before squaring, so its square by 2**28.
   localparam int KNEE_SHIFT = 28;

endpackage

`default_nettype wire

FILE: rtl/core/pks_if.sv
// Valid/ready channel interfaces for the point stream and the split-segment stream.
`default_nettype none

interface pks_req_if;
   logic                          valid;
   logic                          ready;
   logic [pks_pkg::COORD_W-1:0]   point_x;
   logic [pks_pkg::COORD_W-1:0]   point_y;
   logic                          line_last;

   modport source (output valid, point_x, point_y, line_last, input ready);
   modport sink   (input valid, point_x, point_y, line_last, output ready);
endinterface

interface pks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pks_pkg::COORD_W-1:0]   out_x;
   logic [pks_pkg::COORD_W-1:0]   out_y;
   logic                          segment_last;
   logic                          is_knee;

   modport source (output valid, out_x, out_y, segment_last, is_knee, input ready);
   modport sink   (input valid, out_x, out_y, segment_last, is_knee, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/polyline_knee_splitter.sv
// Polyline knee splitter: classifies interior points and re-emits split segments.
// An interior point runs through the radix-2 shift-add multiplier (one bit per cycle)
// and the bit-serial magnitude comparator, on W = min(COORD_BITS, 16) bit coordinates,
// before its first output item. Other points skip both.
// One input item is worked on at a time; an output register decouples the result side.
// Synchronous active-high reset clears the state machine, the output valid and the threshold.
`default_nettype none

module polyline_knee_splitter #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   pks_req_if.sink                         req_chan,
   pks_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic [pks_pkg::THR_W-1:0]  csr_wdata
);

   // Only the low COORD_BITS bits of a coordinate take part; the fields hold at most
   // COORD_W bits, so the working coordinate width CW is clipped to COORD_W.
   localparam int CW = (COORD_BITS < pks_pkg::COORD_W) ? COORD_BITS : pks_pkg::COORD_W;
   // Sum of two squares, and the signed dot product.
   localparam int SW = 2 * CW + 1;
   localparam int DW = 2 * CW + 2;
   // Multiplicand width: the widest of the sums, the dot magnitude and the threshold square.
   localparam int MW = (SW > pks_pkg::TSQ_W) ? SW : pks_pkg::TSQ_W;
   // Multiplier width: the longest multiplier is the product of the two sums of squares.
   localparam int NB = 4 * CW + 2;
   // Shift register of the multiplier: high accumulator half and the multiplier bits.
   localparam int RW = MW + 1 + NB;
   // Width of both sides of the final comparison.
   localparam int PW = NB + pks_pkg::TSQ_W - 1;
   localparam int CNT_W = $clog2(PW + 1);

   // The sequencer runs one multiply per step. The steps below build, in order, the two
   // sums of squared neighbor distances, the signed dot product, the product of the sums,
   // the squared threshold, the right-hand side of the test and the squared dot product.
   typedef enum logic [3:0] {
      STEP_AXX,
      STEP_AYY,
      STEP_BXX,
      STEP_BYY,
      STEP_DX,
      STEP_DY,
      STEP_SS,
      STEP_TT,
      STEP_ST,
      STEP_MAG
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_STORE,
      ST_CMP,
      ST_DECIDE,
      ST_EMIT_PEND,
      ST_EMIT_KNEE,
      ST_EMIT_LAST
   } state_type;

   // Control state.
   state_type                  state_ff, state_in;
   step_type                   step_ff, step_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [1:0]                 seen_ff, seen_in;
   logic [pks_pkg::THR_W-1:0]  thr_ff, thr_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Point history: the point before the pending one, the pending one and its successor.
   logic [CW-1:0]              older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic [CW-1:0]              pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [CW-1:0]              nxt_x_ff, nxt_x_in, nxt_y_ff, nxt_y_in;
   logic                       last_ff, last_in;
   logic                       knee_ff, knee_in;

   // Arithmetic registers.
   logic [RW-1:0]              mul_ff, mul_in;
   logic [MW-1:0]              mcand_ff, mcand_in;
   logic [SW-1:0]              s1_ff, s1_in, s2_ff, s2_in;
   logic [DW-1:0]              dot_ff, dot_in;
   logic [pks_pkg::TSQ_W-1:0]  tt_ff, tt_in;
   logic [PW-1:0]              lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic                       gt_ff, gt_in, lt_ff, lt_in;

   // Output register.
   logic [pks_pkg::COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                        seg_last_ff, seg_last_in, is_knee_ff, is_knee_in;

   // Neighbor differences as magnitude and sign, taken from the held points.
   logic [CW-1:0]              ax_mag, ay_mag, bx_mag, by_mag;
   logic                       ax_neg, ay_neg, bx_neg, by_neg;
   logic                       zero_len;
   logic [SW-1:0]              dot_mag;
   logic                       dot_neg;
   logic [pks_pkg::TMAG_W-1:0] thr_mag;

   // Multiplier data path and product taps.
   logic [MW+1:0]              mul_sum;
   logic [2*CW-1:0]            p_sq;
   logic [NB-1:0]              p_wide;
   logic [pks_pkg::TSQ_W-1:0]  p_tt;
   logic [PW-1:0]              p_st;
   logic [DW-1:0]              dot_term;
   logic                       term_neg;
   logic                       out_free;
   logic                       req_fire;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   assign ax_mag = abs_diff(older_x_ff, pend_x_ff);
   assign ay_mag = abs_diff(older_y_ff, pend_y_ff);
   assign bx_mag = abs_diff(nxt_x_ff, pend_x_ff);
   assign by_mag = abs_diff(nxt_y_ff, pend_y_ff);
   assign ax_neg = older_x_ff < pend_x_ff;
   assign ay_neg = older_y_ff < pend_y_ff;
   assign bx_neg = nxt_x_ff < pend_x_ff;
   assign by_neg = nxt_y_ff < pend_y_ff;

   // A neighbor that coincides with the pending point never makes a knee.
   assign zero_len = ((older_x_ff == pend_x_ff) && (older_y_ff == pend_y_ff)) ||
                     ((nxt_x_ff == pend_x_ff) && (nxt_y_ff == pend_y_ff));

   assign dot_neg = dot_ff[DW-1];
   assign dot_mag = dot_neg ? SW'(~dot_ff + DW'(1)) : SW'(dot_ff);
   assign thr_mag = thr_ff[pks_pkg::THR_W-1] ? (~thr_ff + pks_pkg::TMAG_W'(1)) : thr_ff;

   // One multiplier bit per cycle: add the multiplicand into the high half, shift right.
   assign mul_sum = {1'b0, mul_ff[RW-1:NB]} + (mul_ff[0] ? {2'b00, mcand_ff} : '0);

   // Once all n bits of an n-bit multiplier are consumed, its product starts at bit NB-n.
   assign p_sq   = mul_ff[NB-CW +: 2*CW];
   assign p_wide = mul_ff[NB-SW +: NB];
   assign p_tt   = mul_ff[NB-pks_pkg::TMAG_W +: pks_pkg::TSQ_W];
   assign p_st   = mul_ff[PW-1:0];

   assign term_neg = (step_ff == STEP_DX) ? (ax_neg ^ bx_neg) : (ay_neg ^ by_neg);
   assign dot_term = term_neg ? (~DW'(p_sq) + DW'(1)) : DW'(p_sq);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && (state_ff == ST_IDLE);

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_x       = out_x_ff;
   assign rsp_chan.out_y       = out_y_ff;
   assign rsp_chan.segment_last = seg_last_ff;
   assign rsp_chan.is_knee     = is_knee_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      seen_in      = seen_ff;
      thr_in       = csr_we ? csr_wdata : thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      older_x_in   = older_x_ff;
      older_y_in   = older_y_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      nxt_x_in     = nxt_x_ff;
      nxt_y_in     = nxt_y_ff;
      last_in      = last_ff;
      knee_in      = knee_ff;
      mul_in       = mul_ff;
      mcand_in     = mcand_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      dot_in       = dot_ff;
      tt_in        = tt_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      gt_in        = gt_ff;
      lt_in        = lt_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      seg_last_in  = seg_last_ff;
      is_knee_in   = is_knee_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               nxt_x_in = req_chan.point_x[CW-1:0];
               nxt_y_in = req_chan.point_y[CW-1:0];
               last_in  = req_chan.line_last;
               knee_in  = 1'b0;
               priority if (seen_ff == 2'd0) begin
                  // First point of a line: hold it, or pass a one-point line through.
                  if (req_chan.line_last) begin
                     state_in = ST_EMIT_LAST;
                  end else begin
                     pend_x_in = req_chan.point_x[CW-1:0];
                     pend_y_in = req_chan.point_y[CW-1:0];
                     seen_in   = 2'd1;
                  end
               end else if (seen_ff == 2'd1) begin
                  state_in = ST_EMIT_PEND;
               end else begin
                  step_in  = STEP_AXX;
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            mul_in   = '0;
            state_in = ST_MUL;
            unique case (step_ff)
               STEP_AXX: begin
                  mcand_in        = MW'(ax_mag);
                  mul_in[NB-1:0]  = NB'(ax_mag);
                  cnt_in          = CNT_W'(CW);
                  if (zero_len) begin
                     knee_in  = 1'b0;
                     state_in = ST_EMIT_PEND;
                  end
               end
               STEP_AYY: begin
                  mcand_in        = MW'(ay_mag);
                  mul_in[NB-1:0]  = NB'(ay_mag);
                  cnt_in          = CNT_W'(CW);
               end
               STEP_BXX: begin
                  mcand_in        = MW'(bx_mag);
                  mul_in[NB-1:0]  = NB'(bx_mag);
                  cnt_in          = CNT_W'(CW);
               end
               STEP_BYY: begin
                  mcand_in        = MW'(by_mag);
                  mul_in[NB-1:0]  = NB'(by_mag);
                  cnt_in          = CNT_W'(CW);
               end
               STEP_DX: begin
                  mcand_in        = MW'(ax_mag);
                  mul_in[NB-1:0]  = NB'(bx_mag);
                  cnt_in          = CNT_W'(CW);
               end
               STEP_DY: begin
                  mcand_in        = MW'(ay_mag);
                  mul_in[NB-1:0]  = NB'(by_mag);
                  cnt_in          = CNT_W'(CW);
               end
               STEP_SS: begin
                  mcand_in        = MW'(s1_ff);
                  mul_in[NB-1:0]  = NB'(s2_ff);
                  cnt_in          = CNT_W'(SW);
               end
               STEP_TT: begin
                  mcand_in        = MW'(thr_mag);
                  mul_in[NB-1:0]  = NB'(thr_mag);
                  cnt_in          = CNT_W'(pks_pkg::TMAG_W);
               end
               STEP_ST: begin
                  mcand_in        = MW'(tt_ff);
                  mul_in[NB-1:0]  = rhs_ff[NB-1:0];
                  cnt_in          = CNT_W'(NB);
               end
               STEP_MAG: begin
                  mcand_in        = MW'(dot_mag);
                  mul_in[NB-1:0]  = NB'(dot_mag);
                  cnt_in          = CNT_W'(SW);
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_MUL: begin
            mul_in = {mul_sum, mul_ff[NB-1:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            state_in = ST_LOAD;
            unique case (step_ff)
               STEP_AXX: begin
                  s1_in   = SW'(p_sq);
                  step_in = STEP_AYY;
               end
               STEP_AYY: begin
                  s1_in   = s1_ff + SW'(p_sq);
                  step_in = STEP_BXX;
               end
               STEP_BXX: begin
                  s2_in   = SW'(p_sq);
                  step_in = STEP_BYY;
               end
               STEP_BYY: begin
                  s2_in   = s2_ff + SW'(p_sq);
                  step_in = STEP_DX;
               end
               STEP_DX: begin
                  dot_in  = dot_term;
                  step_in = STEP_DY;
               end
               STEP_DY: begin
                  dot_in  = dot_ff + dot_term;
                  step_in = STEP_SS;
               end
               STEP_SS: begin
                  rhs_in  = PW'(p_wide);
                  step_in = STEP_TT;
               end
               STEP_TT: begin
                  tt_in   = p_tt;
                  step_in = STEP_ST;
               end
               STEP_ST: begin
                  rhs_in  = p_st;
                  step_in = STEP_MAG;
               end
               STEP_MAG: begin
                  lhs_in   = PW'(p_wide) << pks_pkg::KNEE_SHIFT;
                  gt_in    = 1'b0;
                  lt_in    = 1'b0;
                  cnt_in   = CNT_W'(PW);
                  state_in = ST_CMP;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_CMP: begin
            // Least significant bit first: the last differing bit decides the order.
            if (lhs_ff[0] != rhs_ff[0]) begin
               gt_in = lhs_ff[0];
               lt_in = rhs_ff[0];
            end
            lhs_in = {1'b0, lhs_ff[PW-1:1]};
            rhs_in = {1'b0, rhs_ff[PW-1:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            // A negative threshold passes non-obtuse corners and obtuse ones that lose the
            // test; a non-negative one needs an acute corner whose squared test side wins.
            if (thr_ff[pks_pkg::THR_W-1]) begin
               knee_in = !dot_neg || lt_ff;
            end else begin
               knee_in = !dot_neg && (dot_ff != '0) && gt_ff;
            end
            state_in = ST_EMIT_PEND;
         end

         ST_EMIT_PEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pks_pkg::COORD_W'(pend_x_ff);
               out_y_in     = pks_pkg::COORD_W'(pend_y_ff);
               seg_last_in  = knee_ff;
               is_knee_in   = knee_ff;
               priority if (knee_ff) begin
                  state_in = ST_EMIT_KNEE;
               end else if (last_ff) begin
                  state_in = ST_EMIT_LAST;
               end else begin
                  older_x_in = pend_x_ff;
                  older_y_in = pend_y_ff;
                  pend_x_in  = nxt_x_ff;
                  pend_y_in  = nxt_y_ff;
                  seen_in    = 2'd2;
                  state_in   = ST_IDLE;
               end
            end
         end

         ST_EMIT_KNEE: begin
            // The knee point opens the next segment as well.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pks_pkg::COORD_W'(pend_x_ff);
               out_y_in     = pks_pkg::COORD_W'(pend_y_ff);
               seg_last_in  = 1'b0;
               is_knee_in   = 1'b1;
               if (last_ff) begin
                  state_in = ST_EMIT_LAST;
               end else begin
                  older_x_in = pend_x_ff;
                  older_y_in = pend_y_ff;
                  pend_x_in  = nxt_x_ff;
                  pend_y_in  = nxt_y_ff;
                  seen_in    = 2'd2;
                  state_in   = ST_IDLE;
               end
            end
         end

         ST_EMIT_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pks_pkg::COORD_W'(nxt_x_ff);
               out_y_in     = pks_pkg::COORD_W'(nxt_y_ff);
               seg_last_in  = 1'b1;
               is_knee_in   = 1'b0;
               seen_in      = 2'd0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_AXX;
         cnt_ff       <= '0;
         seen_ff      <= 2'd0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         seen_ff      <= seen_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      older_x_ff  <= older_x_in;
      older_y_ff  <= older_y_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      nxt_x_ff    <= nxt_x_in;
      nxt_y_ff    <= nxt_y_in;
      last_ff     <= last_in;
      knee_ff     <= knee_in;
      mul_ff      <= mul_in;
      mcand_ff    <= mcand_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      dot_ff      <= dot_in;
      tt_ff       <= tt_in;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      gt_ff       <= gt_in;
      lt_ff       <= lt_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      seg_last_ff <= seg_last_in;
      is_knee_ff  <= is_knee_in;
   end

endmodule

`default_nettype wire
